>>> rtl/core/bfhs_pkg.sv
// ----------------------------------------------------------------------------
// Back/forward history stacks package
// Shared constants, operation codes, sequencer states and the stack command.
// ----------------------------------------------------------------------------
`default_nettype none

package bfhs_pkg;

   localparam int DEPTH_DEFAULT       = 128;
   localparam int HANDLE_BITS_DEFAULT = 32;

   localparam int PAGE_BITS  = 32;
   localparam int STEP_BITS  = 8;
   localparam int COUNT_BITS = 8;

   typedef enum logic [1:0] {
      OP_VISIT   = 2'd0,
      OP_BACK    = 2'd1,
      OP_FORWARD = 2'd2,
      OP_INIT    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_LOAD,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } stack_cmd_type;

endpackage

`default_nettype wire

>>> rtl/core/bfhs_if.sv
// ----------------------------------------------------------------------------
// Back/forward history stacks channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfhs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [bfhs_pkg::PAGE_BITS-1:0] page_id;
   logic [bfhs_pkg::STEP_BITS-1:0] step_count;

   modport source (output valid, output operation, output page_id,
                   output step_count, input ready);
   modport sink   (input valid, input operation, input page_id,
                   input step_count, output ready);
endinterface

interface bfhs_rsp_if;
   logic        valid;
   logic        ready;
   logic [bfhs_pkg::PAGE_BITS-1:0]  current_page;
   logic                            status;
   logic [bfhs_pkg::COUNT_BITS-1:0] back_depth;
   logic [bfhs_pkg::COUNT_BITS-1:0] forward_depth;

   modport source (output valid, output current_page, output status,
                   output back_depth, output forward_depth, input ready);
   modport sink   (input valid, input current_page, input status,
                   input back_depth, input forward_depth, output ready);
endinterface

`default_nettype wire

>>> rtl/core/back_forward_history_stacks_top.sv
// ----------------------------------------------------------------------------
// Back/forward history stacks
// Current page plus back and forward stacks of page handles, walked one
// entry per step by a small sequencer.
//
//   Channel    Dir  Signals                                        Handshake
//   req_chan   in   operation, page_id, step_count                 valid/ready
//   rsp_chan   out  current_page, status, back_depth, forward_depth valid/ready
//   csr_*      in   csr_we, csr_wdata (home page)                  write enable
//
// Visit, init and rejected walks go from the accepting cycle straight to the
// response state, so the response can be taken in the cycle after accept.
// A walk runs the step and load states once per step: step pushes and pops,
// and load takes the popped word from the stack memory into the current page.
// The response is held until taken, and no new word is accepted meanwhile.
// Reset is synchronous and empties both stacks; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module back_forward_history_stacks_top #(
   parameter int DEPTH       = bfhs_pkg::DEPTH_DEFAULT,
   parameter int HANDLE_BITS = bfhs_pkg::HANDLE_BITS_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   bfhs_req_if.sink                         req_chan,
   bfhs_rsp_if.source                       rsp_chan,
   input  wire                              csr_we,
   input  wire  [bfhs_pkg::PAGE_BITS-1:0]   csr_wdata
);

   localparam int FW = $clog2(DEPTH + 1);
   localparam int CW = FW + bfhs_pkg::STEP_BITS;

   bfhs_pkg::state_type     state_ff;
   bfhs_pkg::state_type     state_in;
   bfhs_pkg::stack_cmd_type back_cmd;
   bfhs_pkg::stack_cmd_type fwd_cmd;
   bfhs_pkg::op_type        op;

   logic [HANDLE_BITS-1:0]  home_ff;
   logic [HANDLE_BITS-1:0]  present_ff;
   logic [HANDLE_BITS-1:0]  present_in;
   logic                    status_ff;
   logic                    status_in;
   logic                    walk_back_ff;
   logic                    walk_back_in;
   logic [bfhs_pkg::STEP_BITS-1:0] remain_ff;
   logic [bfhs_pkg::STEP_BITS-1:0] remain_in;

   logic [FW-1:0]           back_fill;
   logic [FW-1:0]           fwd_fill;
   logic [HANDLE_BITS-1:0]  back_pop;
   logic [HANDLE_BITS-1:0]  fwd_pop;
   logic                    accept;
   logic                    reject;
   logic [FW-1:0]           walk_fill;

   assign op     = bfhs_pkg::op_type'(req_chan.operation);
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      walk_fill = (op == bfhs_pkg::OP_BACK) ? back_fill : fwd_fill;
      reject    = (req_chan.step_count == '0) ||
                  (CW'(req_chan.step_count) > CW'(walk_fill));
   end

   always_comb begin
      state_in     = state_ff;
      present_in   = present_ff;
      status_in    = status_ff;
      walk_back_in = walk_back_ff;
      remain_in    = remain_ff;
      back_cmd     = '0;
      fwd_cmd      = '0;
      unique case (state_ff)
         bfhs_pkg::ST_IDLE: begin
            if (accept) begin
               status_in = 1'b0;
               state_in  = bfhs_pkg::ST_RESP;
               unique case (op)
                  bfhs_pkg::OP_VISIT: begin
                     back_cmd.push = 1'b1;
                     fwd_cmd.clear = 1'b1;
                     present_in    = HANDLE_BITS'(req_chan.page_id);
                  end
                  bfhs_pkg::OP_INIT: begin
                     back_cmd.clear = 1'b1;
                     fwd_cmd.clear  = 1'b1;
                     present_in     = home_ff;
                  end
                  default: begin
                     walk_back_in = (op == bfhs_pkg::OP_BACK);
                     remain_in    = req_chan.step_count;
                     if (reject) begin
                        status_in = 1'b1;
                     end else begin
                        state_in = bfhs_pkg::ST_STEP;
                     end
                  end
               endcase
            end
         end
         bfhs_pkg::ST_STEP: begin
            if (walk_back_ff) begin
               fwd_cmd.push = 1'b1;
               back_cmd.pop = 1'b1;
            end else begin
               back_cmd.push = 1'b1;
               fwd_cmd.pop   = 1'b1;
            end
            state_in = bfhs_pkg::ST_LOAD;
         end
         bfhs_pkg::ST_LOAD: begin
            present_in = walk_back_ff ? back_pop : fwd_pop;
            remain_in  = remain_ff - 1'b1;
            state_in   = (remain_ff == 8'd1) ? bfhs_pkg::ST_RESP : bfhs_pkg::ST_STEP;
         end
         bfhs_pkg::ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = bfhs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bfhs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfhs_pkg::ST_IDLE;
         present_ff   <= '0;
         home_ff      <= '0;
         status_ff    <= 1'b0;
         walk_back_ff <= 1'b0;
         remain_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         present_ff   <= present_in;
         status_ff    <= status_in;
         walk_back_ff <= walk_back_in;
         remain_ff    <= remain_in;
         if (csr_we) begin
            home_ff <= HANDLE_BITS'(csr_wdata);
         end
      end
   end

   bfhs_stack #(
      .DEPTH       (DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (back_cmd),
      .push_data (present_ff),
      .fill      (back_fill),
      .pop_data  (back_pop)
   );

   bfhs_stack #(
      .DEPTH       (DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_fwd (
      .clock     (clock),
      .reset     (reset),
      .cmd       (fwd_cmd),
      .push_data (present_ff),
      .fill      (fwd_fill),
      .pop_data  (fwd_pop)
   );

   assign req_chan.ready        = (state_ff == bfhs_pkg::ST_IDLE);
   assign rsp_chan.valid        = (state_ff == bfhs_pkg::ST_RESP);
   assign rsp_chan.current_page = bfhs_pkg::PAGE_BITS'(present_ff);
   assign rsp_chan.status       = status_ff;

   always_comb begin
      if (CW'(back_fill) > CW'(255)) begin
         rsp_chan.back_depth = 8'd255;
      end else begin
         rsp_chan.back_depth = bfhs_pkg::COUNT_BITS'(back_fill);
      end
      if (CW'(fwd_fill) > CW'(255)) begin
         rsp_chan.forward_depth = 8'd255;
      end else begin
         rsp_chan.forward_depth = bfhs_pkg::COUNT_BITS'(fwd_fill);
      end
   end

`ifndef SYNTHESIS
   a_back_fill_bound: assert property (@(posedge clock) disable iff (reset)
      CW'(back_fill) <= CW'(DEPTH))
      else $error("Back stack fill exceeds its depth.");

   a_fwd_fill_bound: assert property (@(posedge clock) disable iff (reset)
      CW'(fwd_fill) <= CW'(DEPTH))
      else $error("Forward stack fill exceeds its depth.");

   a_load_after_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfhs_pkg::ST_LOAD) |-> ($past(state_ff) == bfhs_pkg::ST_STEP))
      else $error("Load cycle without a preceding step cycle.");

   a_step_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfhs_pkg::ST_STEP) |-> (remain_ff != '0))
      else $error("Step cycle with no steps remaining.");

   a_accept_exclusive: assert property (@(posedge clock) disable iff (reset)
      accept |-> !rsp_chan.valid)
      else $error("Request word taken while a response is pending.");
`endif

endmodule

`default_nettype wire

>>> rtl/core/bfhs_stack.sv
// ----------------------------------------------------------------------------
// Bounded handle stack
// Memory with a fill count; one push, pop or clear per cycle, registered pop data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfhs_stack #(
   parameter int DEPTH       = bfhs_pkg::DEPTH_DEFAULT,
   parameter int HANDLE_BITS = bfhs_pkg::HANDLE_BITS_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire bfhs_pkg::stack_cmd_type cmd,
   input  wire  [HANDLE_BITS-1:0]       push_data,
   output logic [$clog2(DEPTH+1)-1:0]   fill,
   output logic [HANDLE_BITS-1:0]       pop_data
);

   localparam int IW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);

   logic [HANDLE_BITS-1:0] mem [DEPTH];
   logic [FW-1:0]          fill_ff;
   logic [FW-1:0]          fill_in;
   logic [FW-1:0]          top_index;
   logic                   full;
   logic [HANDLE_BITS-1:0] pop_data_ff;

   assign full      = (fill_ff == FW'(DEPTH));
   assign top_index = fill_ff - FW'(1);

   always_comb begin
      fill_in = fill_ff;
      if (cmd.clear) begin
         fill_in = '0;
      end else if (cmd.push) begin
         if (!full) begin
            fill_in = fill_ff + FW'(1);
         end
      end else if (cmd.pop) begin
         fill_in = top_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push && !cmd.clear && !full) begin
         mem[fill_ff[IW-1:0]] <= push_data;
      end
      if (cmd.pop) begin
         pop_data_ff <= mem[top_index[IW-1:0]];
      end
   end

   assign fill     = fill_ff;
   assign pop_data = pop_data_ff;

endmodule

`default_nettype wire
